[rtl/luma_motion_vector_predictor_macros.svh]
// assertion macros for the luma motion vector predictor
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef LUMA_MOTION_VECTOR_PREDICTOR_MACROS_SVH
`define LUMA_MOTION_VECTOR_PREDICTOR_MACROS_SVH

// checked only while out of reset
`define LMVP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define LMVP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/lmvp_pkg.sv]
// types, codes and helpers for the luma motion vector predictor
// no dependencies
package lmvp_pkg;

  localparam int MV_WIDTH_DEF = 16;
  localparam int MV_W         = 16;
  localparam int REF_W        = 6;
  localparam int CUR_W        = 5;

  typedef enum logic [2:0] {
    SRC_MEDIAN = 3'd0,
    SRC_A      = 3'd1,
    SRC_B      = 3'd2,
    SRC_C      = 3'd3,
    SRC_SKIP   = 3'd4
  } src_e_t;

  typedef enum logic [2:0] {
    PC_16X16  = 3'd0,
    PC_16X8_T = 3'd1,
    PC_16X8_B = 3'd2,
    PC_8X16_L = 3'd3,
    PC_8X16_R = 3'd4
  } pc_e_t;

  localparam logic signed [REF_W-1:0] REF_INTRA = -6'sd1;

  typedef logic signed [MV_W-1:0] mvc_t;

  // decoded neighbours after the skip test and the b/c substitution
  typedef struct packed {
    logic   skip_zero;
    pc_e_t  pc;
    logic   a_eq;
    logic   b_eq;
    logic   c_eq;
    logic   sa_eq;
    logic   sb_eq;
    logic   sc_eq;
    mvc_t   ax;
    mvc_t   ay;
    mvc_t   bx;
    mvc_t   by;
    mvc_t   cx;
    mvc_t   cy;
    mvc_t   dx;
    mvc_t   dy;
  } s1_t;

  // chosen predictor with its difference
  typedef struct packed {
    src_e_t src;
    mvc_t   px;
    mvc_t   py;
    mvc_t   dx;
    mvc_t   dy;
  } s2_t;

  function automatic mvc_t med3(input mvc_t a, input mvc_t b, input mvc_t c);
    mvc_t lo;
    mvc_t hi;
    mvc_t m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

[rtl/luma_motion_vector_predictor.sv]
// luma motion vector predictor, list 0, one partition per request
// depends on lmvp_pkg and luma_motion_vector_predictor_macros.svh
//
// usage:
//   input channel in_*: one partition per request (skip flag, partition
//   case, current reference, neighbour a/b/c reference codes and packed
//   vectors, vector difference). accepted when in_valid is high and
//   in_stall is low.
//   result channel out_*: final vector and predictor source, taken when
//   out_valid is high and out_stall is low.
//   pipeline: three register stages (neighbour decode, predictor select
//   and median, difference add and wrap) between request and result.
//   throughput: one request per cycle unless out_stall holds the pipe;
//   every stage holds its own valid.
//   stall: out_stall freezes the output stage; each earlier stage only
//   holds when the stage after it is full and held, so bubbles are
//   squeezed out and in_stall rises only with all three stages full.
//   reset: synchronous, clears all stage valids; the block can take a new
//   request as soon as reset is released.
module luma_motion_vector_predictor #(
  parameter int MV_WIDTH = lmvp_pkg::MV_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_is_skip,
  input  logic [2:0]                          in_part_case,
  input  logic [lmvp_pkg::CUR_W-1:0]          in_cur_ref,
  input  logic signed [lmvp_pkg::REF_W-1:0]   in_a_ref,
  input  logic [31:0]                         in_a_mv,
  input  logic signed [lmvp_pkg::REF_W-1:0]   in_b_ref,
  input  logic [31:0]                         in_b_mv,
  input  logic signed [lmvp_pkg::REF_W-1:0]   in_c_ref,
  input  logic [31:0]                         in_c_mv,
  input  logic signed [lmvp_pkg::MV_W-1:0]    in_mvd_x,
  input  logic signed [lmvp_pkg::MV_W-1:0]    in_mvd_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lmvp_pkg::MV_W-1:0]    out_mv_x,
  output logic signed [lmvp_pkg::MV_W-1:0]    out_mv_y,
  output logic [2:0]                          out_pred_source
);
  import lmvp_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic signed [MV_W-1:0] mvx_r, mvx_nxt, mvy_r, mvy_nxt;
  logic [2:0] src_r, src_nxt;
  logic stall1, stall2, stall3;

  assign stall3   = s3_v_r && out_stall;
  assign stall2   = s2_v_r && stall3;
  assign stall1   = s1_v_r && stall2;
  assign in_stall = stall1;

  // stage 1: neighbour decode
  logic a_use, b_use, c_use, a_abs, b_abs, c_abs;
  logic [CUR_W-1:0] cur;
  mvc_t ax, ay, bx, by, cx, cy;
  logic a_eq, b_eq, c_eq, subst;

  always_comb begin
    a_use = !in_a_ref[REF_W-1];
    b_use = !in_b_ref[REF_W-1];
    c_use = !in_c_ref[REF_W-1];
    a_abs = in_a_ref[REF_W-1] && (in_a_ref != REF_INTRA);
    b_abs = in_b_ref[REF_W-1] && (in_b_ref != REF_INTRA);
    c_abs = in_c_ref[REF_W-1] && (in_c_ref != REF_INTRA);
    cur   = in_is_skip ? '0 : in_cur_ref;
    ax = a_use ? in_a_mv[15:0]  : '0;
    ay = a_use ? in_a_mv[31:16] : '0;
    bx = b_use ? in_b_mv[15:0]  : '0;
    by = b_use ? in_b_mv[31:16] : '0;
    cx = c_use ? in_c_mv[15:0]  : '0;
    cy = c_use ? in_c_mv[31:16] : '0;
    a_eq = a_use && (in_a_ref[CUR_W-1:0] == cur);
    b_eq = b_use && (in_b_ref[CUR_W-1:0] == cur);
    c_eq = c_use && (in_c_ref[CUR_W-1:0] == cur);
    subst = b_abs && c_abs && !a_abs;

    s1_nxt.skip_zero = in_is_skip && (a_abs || b_abs ||
                       (a_use && in_a_ref[CUR_W-1:0] == '0 && in_a_mv == '0) ||
                       (b_use && in_b_ref[CUR_W-1:0] == '0 && in_b_mv == '0));
    if (in_is_skip) begin
      s1_nxt.pc = PC_16X16;
    end else begin
      unique case (in_part_case)
        PC_16X8_T: s1_nxt.pc = PC_16X8_T;
        PC_16X8_B: s1_nxt.pc = PC_16X8_B;
        PC_8X16_L: s1_nxt.pc = PC_8X16_L;
        PC_8X16_R: s1_nxt.pc = PC_8X16_R;
        default:   s1_nxt.pc = PC_16X16;
      endcase
    end
    s1_nxt.a_eq  = a_eq;
    s1_nxt.b_eq  = b_eq;
    s1_nxt.c_eq  = c_eq;
    s1_nxt.sa_eq = a_eq;
    s1_nxt.sb_eq = subst ? a_eq : b_eq;
    s1_nxt.sc_eq = subst ? a_eq : c_eq;
    s1_nxt.ax = ax;
    s1_nxt.ay = ay;
    s1_nxt.bx = subst ? ax : bx;
    s1_nxt.by = subst ? ay : by;
    s1_nxt.cx = subst ? ax : cx;
    s1_nxt.cy = subst ? ay : cy;
    s1_nxt.dx = in_is_skip ? '0 : in_mvd_x;
    s1_nxt.dy = in_is_skip ? '0 : in_mvd_y;
  end

  // stage 2: skip zero, directional rules, single match, median
  logic one_match;

  always_comb begin
    one_match = (s1_r.sa_eq ^ s1_r.sb_eq ^ s1_r.sc_eq) &&
                !(s1_r.sa_eq && s1_r.sb_eq && s1_r.sc_eq);
    s2_nxt.dx = s1_r.dx;
    s2_nxt.dy = s1_r.dy;
    priority if (s1_r.skip_zero) begin
      s2_nxt.src = SRC_SKIP;
      s2_nxt.px  = '0;
      s2_nxt.py  = '0;
    end else if (s1_r.pc == PC_16X8_T && s1_r.b_eq) begin
      s2_nxt.src = SRC_B;
      s2_nxt.px  = s1_r.bx;
      s2_nxt.py  = s1_r.by;
    end else if ((s1_r.pc == PC_16X8_B || s1_r.pc == PC_8X16_L) && s1_r.a_eq) begin
      s2_nxt.src = SRC_A;
      s2_nxt.px  = s1_r.ax;
      s2_nxt.py  = s1_r.ay;
    end else if (s1_r.pc == PC_8X16_R && s1_r.c_eq) begin
      s2_nxt.src = SRC_C;
      s2_nxt.px  = s1_r.cx;
      s2_nxt.py  = s1_r.cy;
    end else if (one_match && s1_r.sa_eq) begin
      s2_nxt.src = SRC_A;
      s2_nxt.px  = s1_r.ax;
      s2_nxt.py  = s1_r.ay;
    end else if (one_match && s1_r.sb_eq) begin
      s2_nxt.src = SRC_B;
      s2_nxt.px  = s1_r.bx;
      s2_nxt.py  = s1_r.by;
    end else if (one_match) begin
      s2_nxt.src = SRC_C;
      s2_nxt.px  = s1_r.cx;
      s2_nxt.py  = s1_r.cy;
    end else begin
      s2_nxt.src = SRC_MEDIAN;
      s2_nxt.px  = med3(s1_r.ax, s1_r.bx, s1_r.cx);
      s2_nxt.py  = med3(s1_r.ay, s1_r.by, s1_r.cy);
    end
  end

  // stage 3: add difference, wrap to MV_WIDTH
  logic signed [MV_W:0]        sum_x, sum_y;
  logic signed [31:0]          sum_x32, sum_y32, ext_x, ext_y;
  logic signed [MV_WIDTH-1:0]  wrap_x, wrap_y;

  always_comb begin
    sum_x   = (MV_W+1)'(s2_r.px) + (MV_W+1)'(s2_r.dx);
    sum_y   = (MV_W+1)'(s2_r.py) + (MV_W+1)'(s2_r.dy);
    sum_x32 = 32'(sum_x);
    sum_y32 = 32'(sum_y);
    wrap_x  = sum_x32[MV_WIDTH-1:0];
    wrap_y  = sum_y32[MV_WIDTH-1:0];
    ext_x   = 32'(wrap_x);
    ext_y   = 32'(wrap_y);
    mvx_nxt = ext_x[MV_W-1:0];
    mvy_nxt = ext_y[MV_W-1:0];
    src_nxt = s2_r.src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (!stall1) s1_v_r <= in_valid;
      if (!stall2) s2_v_r <= s1_v_r;
      if (!stall3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall1) s1_r <= s1_nxt;
    if (!stall2) s2_r <= s2_nxt;
    if (!stall3) begin
      mvx_r <= mvx_nxt;
      mvy_r <= mvy_nxt;
      src_r <= src_nxt;
    end
  end

  assign out_valid       = s3_v_r;
  assign out_mv_x        = mvx_r;
  assign out_mv_y        = mvy_r;
  assign out_pred_source = src_r;

`include "luma_motion_vector_predictor_macros.svh"

  `LMVP_ASSERT(a_stall_full, in_stall |-> (s1_v_r && s2_v_r && out_valid && out_stall), "stall without full pipe")
  `LMVP_ASSERT(a_skip_zero, (out_valid && out_pred_source == SRC_SKIP) |-> (out_mv_x == '0 && out_mv_y == '0), "skip result not zero")
  `LMVP_ASSERT(a_src_range, out_valid |-> (out_pred_source <= SRC_SKIP), "bad predictor source")
  `LMVP_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> (!out_valid && !in_stall), "valid after reset")

endmodule
